// File: rtl/core/blvg_pkg.sv
// Package for the battery low-voltage guard: opcodes, constants and item types.
// No dependencies; used by the step logic, the top level and the testbench.
package blvg_pkg;

    localparam logic [3:0]  ALERT_DELAY     = 4'd10;
    localparam logic [3:0]  FAULT_DELAY     = 4'd2;
    localparam logic [3:0]  ALERT_CAP       = ALERT_DELAY + 4'd1;
    localparam logic [3:0]  RECOVERY_CAP    = 4'd9;
    localparam logic [3:0]  FAULT_OFF_TICKS = 4'd4;

    localparam logic [15:0] MAX_CURRENT_RST = 16'd3000;
    localparam logic [15:0] RAMP_STEP_MA    = 16'd250;
    localparam logic [15:0] LIMIT_FLOOR_MA  = 16'd500;
    localparam logic [13:0] RAMP_UP_MV      = 14'd50;
    localparam logic [13:0] RAMP_DOWN_MV    = 14'd25;
    localparam logic [13:0] THRES_FLOOR_MV  = 14'd2850;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_STEP_CHECK   = 3'd1,
        OP_RAMP_CHECK   = 3'd2,
        OP_RAMP_RESTORE = 3'd3,
        OP_RAMP_LOAD    = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        battery_alert;
        logic        battery_fault;
        logic        battery_high;
        logic        gear_changing;
        logic        need_shutoff;
        logic [3:0]  step_target_mode;
        logic [15:0] gear_current_ma;
        logic [13:0] mode_low_volt_mv;
        logic        two_cell_mode;
        logic [15:0] load_current_ma;
        logic [13:0] load_threshold_mv;
    } in_item_t;

    typedef struct packed {
        logic        request_off;
        logic        request_step_down;
        logic [3:0]  switch_mode;
        logic [15:0] ramp_limit_ma;
        logic [13:0] ramp_threshold_mv;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  alert_timer;
        logic [3:0]  recovery_timer;
        logic [15:0] ramp_limit;
        logic [13:0] ramp_threshold;
    } state_t;

endpackage

// File: rtl/core/blvg_in_if.sv
// Input channel of the battery low-voltage guard: valid/ready plus item fields.
// No dependencies.
interface blvg_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic        battery_alert;
    logic        battery_fault;
    logic        battery_high;
    logic        gear_changing;
    logic        need_shutoff;
    logic [3:0]  step_target_mode;
    logic [15:0] gear_current_ma;
    logic [13:0] mode_low_volt_mv;
    logic        two_cell_mode;
    logic [15:0] load_current_ma;
    logic [13:0] load_threshold_mv;

    modport source (
        output valid, opcode, battery_alert, battery_fault, battery_high,
               gear_changing, need_shutoff, step_target_mode, gear_current_ma,
               mode_low_volt_mv, two_cell_mode, load_current_ma, load_threshold_mv,
        input  ready
    );
    modport sink (
        input  valid, opcode, battery_alert, battery_fault, battery_high,
               gear_changing, need_shutoff, step_target_mode, gear_current_ma,
               mode_low_volt_mv, two_cell_mode, load_current_ma, load_threshold_mv,
        output ready
    );
endinterface

// File: rtl/core/blvg_out_if.sv
// Result channel of the battery low-voltage guard: valid/ready plus result fields.
// No dependencies.
interface blvg_out_if;
    logic        valid;
    logic        ready;
    logic        request_off;
    logic        request_step_down;
    logic [3:0]  switch_mode;
    logic [15:0] ramp_limit_ma;
    logic [13:0] ramp_threshold_mv;

    modport source (
        output valid, request_off, request_step_down, switch_mode,
               ramp_limit_ma, ramp_threshold_mv,
        input  ready
    );
    modport sink (
        input  valid, request_off, request_step_down, switch_mode,
               ramp_limit_ma, ramp_threshold_mv,
        output ready
    );
endinterface

// File: rtl/core/blvg_cfg_if.sv
// Configuration write channel of the battery low-voltage guard.
// No dependencies; carries the single-cell current limit register value.
interface blvg_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] single_cell_max_current_ma;

    modport source (output valid, single_cell_max_current_ma, input ready);
    modport sink (input valid, single_cell_max_current_ma, output ready);
endinterface

// File: rtl/core/blvg_step.sv
// Combinational step of the battery low-voltage guard: next state and result
// for one item. Depends on blvg_pkg.
module blvg_step (
    input  blvg_pkg::in_item_t  item,
    input  blvg_pkg::state_t    state,
    input  logic [15:0]         max_current_ma,
    output blvg_pkg::state_t    state_next,
    output blvg_pkg::out_item_t result
);

    logic [3:0]  at;
    logic [3:0]  rt;
    logic [15:0] lim;
    logic [13:0] thr;
    logic [3:0]  wait_ticks;
    logic [16:0] lim_sum;
    logic [14:0] thr_sum;
    logic        req_off;
    logic        req_step;
    logic [3:0]  sw_mode;

    assign lim_sum = {1'b0, state.ramp_limit} + {1'b0, blvg_pkg::RAMP_STEP_MA};
    assign thr_sum = {1'b0, state.ramp_threshold} + {1'b0, blvg_pkg::RAMP_UP_MV};

    always_comb
    begin
        at         = state.alert_timer;
        rt         = state.recovery_timer;
        lim        = state.ramp_limit;
        thr        = state.ramp_threshold;
        wait_ticks = blvg_pkg::FAULT_DELAY;
        req_off    = 1'b0;
        req_step   = 1'b0;
        sw_mode    = '0;

        unique case (blvg_pkg::op_t'(item.opcode))
            blvg_pkg::OP_TICK:
            begin
                if (rt != 4'd0 && rt < blvg_pkg::RECOVERY_CAP)
                    rt = rt + 4'd1;
                if (at != 4'd0 && at < blvg_pkg::ALERT_CAP)
                    at = at + 4'd1;
            end
            blvg_pkg::OP_STEP_CHECK:
            begin
                if (!item.battery_fault)
                begin
                    wait_ticks = blvg_pkg::ALERT_DELAY;
                    if (!item.battery_alert || item.gear_changing)
                        at = 4'd0;
                    else if (at == 4'd0)
                        at = 4'd1;
                end
                else if (at == 4'd0)
                    at = 4'd1;
                if (at > wait_ticks)
                begin
                    if (item.need_shutoff || (item.gear_changing && item.battery_fault))
                        req_off = 1'b1;
                    else
                    begin
                        at       = 4'd0;
                        req_step = 1'b1;
                        sw_mode  = item.step_target_mode;
                    end
                end
            end
            blvg_pkg::OP_RAMP_CHECK:
            begin
                if (!item.battery_alert && !item.battery_fault)
                begin
                    at = 4'd0;
                    if (item.battery_high)
                    begin
                        if (state.ramp_limit < item.gear_current_ma)
                        begin
                            if (rt == 4'd0 || rt >= blvg_pkg::RECOVERY_CAP)
                            begin
                                rt = 4'd1;
                                if (state.ramp_threshold > item.mode_low_volt_mv)
                                    thr = item.mode_low_volt_mv;
                                else
                                    thr = thr_sum[14] ? '1 : thr_sum[13:0];
                                lim = lim_sum[16] ? '1 : lim_sum[15:0];
                            end
                        end
                        else
                            rt = 4'd0;
                    end
                end
                else
                begin
                    rt = 4'd0;
                    if (at == 4'd0)
                        at = 4'd1;
                    if (item.battery_fault && at > blvg_pkg::FAULT_OFF_TICKS)
                        req_off = 1'b1;
                    else if (at > blvg_pkg::ALERT_DELAY)
                    begin
                        if (lim > blvg_pkg::LIMIT_FLOOR_MA)
                            lim = lim - blvg_pkg::RAMP_STEP_MA;
                        if (thr > blvg_pkg::THRES_FLOOR_MV)
                            thr = thr - blvg_pkg::RAMP_DOWN_MV;
                        at = 4'd1;
                    end
                end
            end
            blvg_pkg::OP_RAMP_RESTORE:
            begin
                if (!item.battery_alert && !item.battery_fault && item.battery_high)
                    lim = item.two_cell_mode ? item.gear_current_ma : max_current_ma;
            end
            blvg_pkg::OP_RAMP_LOAD:
            begin
                lim = item.load_current_ma;
                thr = item.load_threshold_mv;
            end
            default:
            begin
                lim = state.ramp_limit;
            end
        endcase
    end

    assign state_next.alert_timer    = at;
    assign state_next.recovery_timer = rt;
    assign state_next.ramp_limit     = lim;
    assign state_next.ramp_threshold = thr;

    assign result.request_off       = req_off;
    assign result.request_step_down = req_step;
    assign result.switch_mode       = sw_mode;
    assign result.ramp_limit_ma     = lim;
    assign result.ramp_threshold_mv = thr;

endmodule

// File: rtl/core/battery_low_voltage_guard_unit.sv
// Battery low-voltage guard, top level. An input transaction passes through the
// input register, then the result register, before its result is valid.
// Throughput: one transaction per cycle while the result side is not stalled.
// Reset (rst_n low, asynchronous): timers and ramp values cleared, current limit
// register set to 3000 mA, both channel stages empty.
// Depends on blvg_pkg, blvg_in_if, blvg_out_if, blvg_cfg_if and blvg_step.
module battery_low_voltage_guard_unit (
    input  logic          clk,
    input  logic          rst_n,
    blvg_in_if.sink       cmd,
    blvg_out_if.source    rsp,
    blvg_cfg_if.sink      cfg
);

    logic                cmd_valid_reg;
    blvg_pkg::in_item_t  cmd_item_reg;
    blvg_pkg::in_item_t  cmd_item;
    blvg_pkg::state_t    state_reg;
    blvg_pkg::state_t    state_next;
    logic                rsp_valid_reg;
    blvg_pkg::out_item_t rsp_item_reg;
    blvg_pkg::out_item_t rsp_item_next;
    logic [15:0]         max_current_reg;
    logic                fire;
    logic                cmd_take;

    assign cmd_item.opcode            = cmd.opcode;
    assign cmd_item.battery_alert     = cmd.battery_alert;
    assign cmd_item.battery_fault     = cmd.battery_fault;
    assign cmd_item.battery_high      = cmd.battery_high;
    assign cmd_item.gear_changing     = cmd.gear_changing;
    assign cmd_item.need_shutoff      = cmd.need_shutoff;
    assign cmd_item.step_target_mode  = cmd.step_target_mode;
    assign cmd_item.gear_current_ma   = cmd.gear_current_ma;
    assign cmd_item.mode_low_volt_mv  = cmd.mode_low_volt_mv;
    assign cmd_item.two_cell_mode     = cmd.two_cell_mode;
    assign cmd_item.load_current_ma   = cmd.load_current_ma;
    assign cmd_item.load_threshold_mv = cmd.load_threshold_mv;

    assign fire      = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || fire;
    assign cmd_take  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    blvg_step u_step (
        .item           (cmd_item_reg),
        .state          (state_reg),
        .max_current_ma (max_current_reg),
        .state_next     (state_next),
        .result         (rsp_item_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            state_reg       <= '0;
            max_current_reg <= blvg_pkg::MAX_CURRENT_RST;
        end
        else
        begin
            if (cmd.ready)
                cmd_valid_reg <= cmd.valid;
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
            if (cfg.valid)
                max_current_reg <= cfg.single_cell_max_current_ma;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            cmd_item_reg <= cmd_item;
        if (fire)
            rsp_item_reg <= rsp_item_next;
    end

    assign rsp.valid             = rsp_valid_reg;
    assign rsp.request_off       = rsp_item_reg.request_off;
    assign rsp.request_step_down = rsp_item_reg.request_step_down;
    assign rsp.switch_mode       = rsp_item_reg.switch_mode;
    assign rsp.ramp_limit_ma     = rsp_item_reg.ramp_limit_ma;
    assign rsp.ramp_threshold_mv = rsp_item_reg.ramp_threshold_mv;

endmodule

// File: rtl/core/blvg_checker.sv
// Port-level checks for the battery low-voltage guard, with the bind that
// attaches them to battery_low_voltage_guard_unit. No package dependency.
module blvg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic       request_off,
    input logic       request_step_down,
    input logic [3:0] switch_mode
);

    // result held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_req_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(request_off && request_step_down))
        else $error("off and step-down requested together");

    a_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !request_step_down |-> switch_mode == 4'd0)
        else $error("switch_mode set without step-down");

    // empty pipe: a new result comes from an input transaction through the input and result registers
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(cmd_valid && cmd_ready, 2))
        else $error("result without matching input transaction");

endmodule

bind battery_low_voltage_guard_unit blvg_checker u_blvg_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .request_off       (rsp.request_off),
    .request_step_down (rsp.request_step_down),
    .switch_mode       (rsp.switch_mode)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for battery_low_voltage_guard_unit: a directed table, then random phases,
// every result transaction checked against the table's pinned result or an in-bench model of the timers and ramp.
// Depends on blvg_pkg, the three channel interfaces and the RTL top level.
module testbench;

    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [2:0] OP_SPARE    = 3'd7;

    typedef struct packed {
        blvg_pkg::in_item_t  item;
        logic                pinned;
        blvg_pkg::out_item_t result;
    } vector_t;

    localparam blvg_pkg::out_item_t NO_RES = '0;

    logic       clk;
    logic       rst_n;
    logic       steady    = 1'b0;
    logic       hold_go   = 1'b0;
    logic       hold_done = 1'b0;
    logic [7:0] hold_left = 8'd0;
    int         cycle_cnt  = 0;
    int         errors     = 0;
    int         sent_items = 0;

    // guard model state
    logic [3:0]  alert_tmr;
    logic [3:0]  recov_tmr;
    logic [15:0] lim_ma;
    logic [13:0] thr_mv;
    logic [15:0] cell_max_ma;

    blvg_pkg::out_item_t pending_results[$];
    vector_t             dir_tbl[$];

    blvg_in_if  cmd_if();
    blvg_out_if rsp_if();
    blvg_cfg_if cfg_if();

    battery_low_voltage_guard_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic blvg_pkg::out_item_t predict_guard(input blvg_pkg::in_item_t it);
        blvg_pkg::out_item_t r;
        logic [3:0]          wait_lim;
        logic [16:0]         sum_ma;
        logic [14:0]         sum_mv;
        logic                go;
        r = '0;
        case (it.opcode)
            blvg_pkg::OP_TICK:
            begin
                if (recov_tmr != 0 && recov_tmr < blvg_pkg::RECOVERY_CAP)
                    recov_tmr = recov_tmr + 4'd1;
                if (alert_tmr != 0 && alert_tmr < blvg_pkg::ALERT_CAP)
                    alert_tmr = alert_tmr + 4'd1;
            end
            blvg_pkg::OP_STEP_CHECK:
            begin
                wait_lim = blvg_pkg::FAULT_DELAY;
                if (!it.battery_fault)
                begin
                    wait_lim = blvg_pkg::ALERT_DELAY;
                    if (!it.battery_alert || it.gear_changing)
                        alert_tmr = 0;
                    else if (alert_tmr == 0)
                        alert_tmr = 1;
                end
                else if (alert_tmr == 0)
                    alert_tmr = 1;
                if (alert_tmr > wait_lim)
                begin
                    if (it.need_shutoff || (it.gear_changing && it.battery_fault))
                        r.request_off = 1'b1;
                    else
                    begin
                        alert_tmr = 0;
                        r.request_step_down = 1'b1;
                        r.switch_mode = it.step_target_mode;
                    end
                end
            end
            blvg_pkg::OP_RAMP_CHECK:
            begin
                if (!it.battery_alert && !it.battery_fault)
                begin
                    alert_tmr = 0;
                    if (it.battery_high)
                    begin
                        if (lim_ma < it.gear_current_ma)
                        begin
                            go = 1'b1;
                            if (recov_tmr == 0)
                                recov_tmr = 1;
                            else if (recov_tmr < blvg_pkg::RECOVERY_CAP)
                                go = 1'b0;
                            if (go)
                            begin
                                recov_tmr = 1;
                                if (thr_mv > it.mode_low_volt_mv)
                                    thr_mv = it.mode_low_volt_mv;
                                else
                                begin
                                    sum_mv = {1'b0, thr_mv} + {1'b0, blvg_pkg::RAMP_UP_MV};
                                    thr_mv = sum_mv[14] ? 14'h3FFF : sum_mv[13:0];
                                end
                                sum_ma = {1'b0, lim_ma} + {1'b0, blvg_pkg::RAMP_STEP_MA};
                                lim_ma = sum_ma[16] ? 16'hFFFF : sum_ma[15:0];
                            end
                        end
                        else
                            recov_tmr = 0;
                    end
                end
                else
                begin
                    recov_tmr = 0;
                    if (alert_tmr == 0)
                        alert_tmr = 1;
                    if (it.battery_fault && alert_tmr > blvg_pkg::FAULT_OFF_TICKS)
                        r.request_off = 1'b1;
                    else if (alert_tmr > blvg_pkg::ALERT_DELAY)
                    begin
                        if (lim_ma > blvg_pkg::LIMIT_FLOOR_MA)
                            lim_ma = lim_ma - blvg_pkg::RAMP_STEP_MA;
                        if (thr_mv > blvg_pkg::THRES_FLOOR_MV)
                            thr_mv = thr_mv - blvg_pkg::RAMP_DOWN_MV;
                        alert_tmr = 1;
                    end
                end
            end
            blvg_pkg::OP_RAMP_RESTORE:
            begin
                if (!it.battery_alert && !it.battery_fault && it.battery_high)
                    lim_ma = it.two_cell_mode ? it.gear_current_ma : cell_max_ma;
            end
            blvg_pkg::OP_RAMP_LOAD:
            begin
                lim_ma = it.load_current_ma;
                thr_mv = it.load_threshold_mv;
            end
            default:
            begin
            end
        endcase
        r.ramp_limit_ma = lim_ma;
        r.ramp_threshold_mv = thr_mv;
        return r;
    endfunction

    function automatic blvg_pkg::in_item_t stim(input logic [2:0] op, input logic a,
                                                input logic f, input logic p, input logic g,
                                                input logic s, input logic [3:0] tgt,
                                                input logic [15:0] gma,
                                                input logic [13:0] mmv, input logic tc,
                                                input logic [15:0] lma,
                                                input logic [13:0] lmv);
        return '{op, a, f, p, g, s, tgt, gma, mmv, tc, lma, lmv};
    endfunction

    function automatic blvg_pkg::out_item_t res(input logic off, input logic stp,
                                                input logic [3:0] md,
                                                input logic [15:0] lim,
                                                input logic [13:0] thr);
        return '{off, stp, md, lim, thr};
    endfunction

    function automatic blvg_pkg::in_item_t rand_item(input logic [2:0] op, input logic a,
                                                     input logic f);
        blvg_pkg::in_item_t it;
        it.opcode            = op;
        it.battery_alert     = a;
        it.battery_fault     = f;
        it.battery_high      = $urandom_range(0, 1);
        it.gear_changing     = $urandom_range(0, 1);
        it.need_shutoff      = $urandom_range(0, 1);
        it.step_target_mode  = $urandom_range(0, 15);
        it.gear_current_ma   = $urandom_range(0, 65535);
        it.mode_low_volt_mv  = $urandom_range(0, 16383);
        it.two_cell_mode     = $urandom_range(0, 1);
        it.load_current_ma   = $urandom_range(0, 65535);
        it.load_threshold_mv = $urandom_range(0, 16383);
        return it;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endtask

    task automatic send(input blvg_pkg::in_item_t it, input logic pinned,
                        input blvg_pkg::out_item_t pin_res);
        blvg_pkg::out_item_t predicted;
        if (!steady && $urandom_range(0, 99) < 14)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_if.valid             <= 1'b1;
        cmd_if.opcode            <= it.opcode;
        cmd_if.battery_alert     <= it.battery_alert;
        cmd_if.battery_fault     <= it.battery_fault;
        cmd_if.battery_high      <= it.battery_high;
        cmd_if.gear_changing     <= it.gear_changing;
        cmd_if.need_shutoff      <= it.need_shutoff;
        cmd_if.step_target_mode  <= it.step_target_mode;
        cmd_if.gear_current_ma   <= it.gear_current_ma;
        cmd_if.mode_low_volt_mv  <= it.mode_low_volt_mv;
        cmd_if.two_cell_mode     <= it.two_cell_mode;
        cmd_if.load_current_ma   <= it.load_current_ma;
        cmd_if.load_threshold_mv <= it.load_threshold_mv;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        predicted = predict_guard(it);
        pending_results.push_back(pinned ? pin_res : predicted);
        sent_items++;
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input logic [15:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.single_cell_max_current_ma <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cell_max_ma = v;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send(rand_item(blvg_pkg::OP_TICK, $urandom_range(0, 1), $urandom_range(0, 1)),
                 1'b0, NO_RES);
    endtask

    // mostly well-formed alert/fault/ramp sequences, some noise
    task automatic random_phase(input int count);
        blvg_pkg::in_item_t it;
        int                 stop_at;
        logic               f;
        stop_at = sent_items + count;
        while (sent_items < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    it = rand_item(blvg_pkg::OP_STEP_CHECK, 1'b1, 1'b0);
                    it.gear_changing = 1'b0;
                    send(it, 1'b0, NO_RES);
                    send_ticks($urandom_range(7, 12));
                    it = rand_item(blvg_pkg::OP_STEP_CHECK, 1'b1, $urandom_range(0, 3) == 0);
                    it.gear_changing = ($urandom_range(0, 4) == 0);
                    send(it, 1'b0, NO_RES);
                end
                2:
                begin
                    send(rand_item(blvg_pkg::OP_STEP_CHECK, $urandom_range(0, 1), 1'b1),
                         1'b0, NO_RES);
                    send_ticks($urandom_range(0, 3));
                    send(rand_item(blvg_pkg::OP_STEP_CHECK, $urandom_range(0, 1), 1'b1),
                         1'b0, NO_RES);
                end
                3, 4:
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        f = ($urandom_range(0, 3) == 0);
                        it = rand_item(blvg_pkg::OP_RAMP_CHECK,
                                       f ? $urandom_range(0, 1) : 1'b1, f);
                        send(it, 1'b0, NO_RES);
                        send_ticks($urandom_range(3, 11));
                    end
                end
                5, 6:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        it = rand_item(blvg_pkg::OP_RAMP_CHECK, 1'b0, 1'b0);
                        it.battery_high = ($urandom_range(0, 7) != 0);
                        send(it, 1'b0, NO_RES);
                        send_ticks($urandom_range(0, 9));
                    end
                end
                7:
                begin
                    it = rand_item(blvg_pkg::OP_RAMP_RESTORE, $urandom_range(0, 3) == 0,
                                   $urandom_range(0, 3) == 0);
                    it.battery_high = ($urandom_range(0, 3) != 0);
                    send(it, 1'b0, NO_RES);
                end
                8:
                begin
                    it = rand_item(blvg_pkg::OP_RAMP_LOAD, $urandom_range(0, 1),
                                   $urandom_range(0, 1));
                    if ($urandom_range(0, 1))
                    begin
                        it.load_current_ma = 16'hFFFF - $urandom_range(0, 600);
                        it.load_threshold_mv = $urandom_range(0, 1) ?
                            14'h3FFF - $urandom_range(0, 100) : 14'd2800 + $urandom_range(0, 100);
                    end
                    send(it, 1'b0, NO_RES);
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                        send(rand_item($urandom_range(0, 7), $urandom_range(0, 1),
                                       $urandom_range(0, 1)), 1'b0, NO_RES);
                end
            endcase
        end
    endtask

    // result side: random stalls, one long hold-off once asked for
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 8'd1;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= 8'd80;
            hold_done <= 1'b1;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= steady || ($urandom_range(0, 99) >= 14);
    end

    always @(posedge clk)
    begin : result_check
        blvg_pkg::out_item_t got;
        blvg_pkg::out_item_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.request_off       = rsp_if.request_off;
            got.request_step_down = rsp_if.request_step_down;
            got.switch_mode       = rsp_if.switch_mode;
            got.ramp_limit_ma     = rsp_if.ramp_limit_ma;
            got.ramp_threshold_mv = rsp_if.ramp_threshold_mv;
            if (pending_results.size() == 0)
                note_error($sformatf("unexpected transaction: off=%0d step=%0d mode=%0d lim=%0d thr=%0d",
                                     got.request_off, got.request_step_down, got.switch_mode,
                                     got.ramp_limit_ma, got.ramp_threshold_mv));
            else
            begin
                want = pending_results.pop_front();
                if (got.request_off !== want.request_off ||
                    got.request_step_down !== want.request_step_down ||
                    got.switch_mode !== want.switch_mode ||
                    got.ramp_limit_ma !== want.ramp_limit_ma ||
                    got.ramp_threshold_mv !== want.ramp_threshold_mv)
                    note_error($sformatf({"mismatch: expected off=%0d step=%0d mode=%0d ",
                                          "lim=%0d thr=%0d, got off=%0d step=%0d mode=%0d ",
                                          "lim=%0d thr=%0d"},
                                         want.request_off, want.request_step_down,
                                         want.switch_mode, want.ramp_limit_ma,
                                         want.ramp_threshold_mv, got.request_off,
                                         got.request_step_down, got.switch_mode,
                                         got.ramp_limit_ma, got.ramp_threshold_mv));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("battery_low_voltage_guard_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = blvg_pkg::OP_TICK;
        cmd_if.battery_alert = 1'b0;
        cmd_if.battery_fault = 1'b0;
        cmd_if.battery_high = 1'b0;
        cmd_if.gear_changing = 1'b0;
        cmd_if.need_shutoff = 1'b0;
        cmd_if.step_target_mode = '0;
        cmd_if.gear_current_ma = '0;
        cmd_if.mode_low_volt_mv = '0;
        cmd_if.two_cell_mode = 1'b0;
        cmd_if.load_current_ma = '0;
        cmd_if.load_threshold_mv = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.single_cell_max_current_ma = '0;
        alert_tmr = '0;
        recov_tmr = '0;
        lim_ma = '0;
        thr_mv = '0;
        cell_max_ma = blvg_pkg::MAX_CURRENT_RST;

        // opcode, alert, fault, high, gear, shutoff, target, gear mA, mode mV,
        // two cell, load mA, load mV
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1'b1, res(0, 0, 0, 0, 0)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                         65535, 16383),
                                    1'b1, res(0, 0, 0, 65535, 16383)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_LOAD, 1, 1, 1, 1, 1, 15, 65535,
                                         16383, 1, 0, 0),
                                    1'b1, res(0, 0, 0, 0, 0)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_RESTORE, 0, 0, 1, 0, 0, 0, 777, 0,
                                         0, 0, 0),
                                    1'b1, res(0, 0, 0, 65535, 0)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_RESTORE, 0, 0, 1, 0, 0, 0, 1234, 0,
                                         1, 0, 0),
                                    1'b1, res(0, 0, 0, 1234, 0)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_RESTORE, 1, 0, 1, 0, 0, 0, 99, 0,
                                         1, 0, 0),
                                    1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(OP_SPARE, 1, 1, 1, 1, 1, 15, 65535, 16383, 1, 65535,
                                         16383), 1'b1, res(0, 0, 0, 1234, 0)});
        // fault in stepped check: step down after the short delay
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_STEP_CHECK, 0, 1, 0, 0, 0, 15, 0, 0, 0,
                                         0, 0),
                                    1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_STEP_CHECK, 0, 1, 0, 0, 0, 15, 0, 0, 0,
                                         0, 0),
                                    1'b1, res(0, 1, 15, 1234, 0)});
        // fault during a gear change: shut off
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_STEP_CHECK, 0, 1, 0, 1, 0, 6, 0, 0, 0,
                                         0, 0),
                                    1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_TICK, 1, 1, 1, 1, 1, 15, 65535, 16383,
                                         1, 65535, 16383), 1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                    1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_STEP_CHECK, 0, 1, 0, 1, 0, 6, 0, 0, 0,
                                         0, 0),
                                    1'b1, res(1, 0, 0, 1234, 0)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_STEP_CHECK, 0, 0, 0, 0, 1, 3, 0, 0, 0,
                                         0, 0),
                                    1'b0, NO_RES});
        // ramp rise saturates at field maximum
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                         65500, 16350),
                                    1'b1, res(0, 0, 0, 65500, 16350)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_CHECK, 0, 0, 1, 0, 0, 0, 65535,
                                         16383, 0, 0, 0),
                                    1'b1, res(0, 0, 0, 65535, 16383)});
        // ramp fault requests off once the alert timer passes four
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                         3000, 3000),
                                    1'b1, res(0, 0, 0, 3000, 3000)});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_CHECK, 0, 1, 0, 0, 0, 0, 0, 0, 0,
                                         0, 0),
                                    1'b0, NO_RES});
        repeat (4)
            dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                             0),
                                        1'b0, NO_RES});
        dir_tbl.push_back(vector_t'{stim(blvg_pkg::OP_RAMP_CHECK, 0, 1, 0, 0, 0, 0, 0, 0, 0,
                                         0, 0),
                                    1'b1, res(1, 0, 0, 3000, 3000)});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_cfg(16'hFFFF);
        foreach (dir_tbl[i])
            send(dir_tbl[i].item, dir_tbl[i].pinned, dir_tbl[i].result);

        drain();
        write_cfg(16'h0000);
        hold_go <= 1'b1;
        random_phase(130);

        drain();
        write_cfg(16'($urandom_range(0, 65535)));
        steady <= 1'b1;
        random_phase(130);
        steady <= 1'b0;

        drain();
        write_cfg(blvg_pkg::MAX_CURRENT_RST);
        random_phase(140);

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("battery_low_voltage_guard_unit regression: pass");
        else
            $display("battery_low_voltage_guard_unit regression: fail");
        $finish;
    end

endmodule
